// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and arithmetic helpers for the segment decoder.
// ----------------------------------------------------------------------------
package msp_pkg;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MAGIC = 3'd1,
    ST_STALE = 3'd2,
    ST_FEW   = 3'd3,
    ST_SHORT = 3'd4
  } status_t;

  // One unit of work passed from the parser to the decoder.
  typedef struct packed {
    logic [255:0] data;
    logic         has_seg;
    logic         seg_last;
    status_t      status;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_READ,
    BK_MUL,
    BK_FIN,
    BK_EMIT
  } back_state_t;

  localparam int BONES = 23;
  localparam logic [4:0] NO_PARENT = 5'h1F;
  localparam logic [31:0] Q_ONE = 32'h4000_0000;

  localparam logic [7:0] MAGIC [6] = '{8'h4D, 8'h58, 8'h54, 8'h50, 8'h30, 8'h32};

  localparam logic [4:0] PARENT [BONES] = '{
    NO_PARENT, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd4, 5'd7, 5'd8, 5'd9, 5'd4,
    5'd11, 5'd12, 5'd13, 5'd0, 5'd15, 5'd16, 5'd17, 5'd0, 5'd19, 5'd20, 5'd21
  };

  // Float conversion order: w, x, y, z of the rotation, then position x, y, z.
  localparam logic [2:0] CONV_WORD [7] = '{3'd4, 3'd6, 3'd5, 3'd7, 3'd2, 3'd1, 3'd3};
  localparam logic       CONV_NEG  [7] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

  // Sixteen terms of conj(p) * q, four per result component.
  localparam logic [1:0] A_SEL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3
  };
  localparam logic [1:0] B_SEL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0
  };
  localparam logic T_NEG [16] = '{
    1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
  };

  function automatic logic [31:0] from_mag(input logic neg, input logic [65:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag >= 66'h0_8000_0000) r = 32'h8000_0000;
      else r = 32'(-mag[31:0]);
    end else begin
      if (mag > 66'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  // Float bits to Q1.30 (rotation) or to centimetres in Q16.16 (position).
  function automatic logic [31:0] to_fixed(input logic [31:0] bits, input logic is_pos);
    logic              neg;
    logic [7:0]        ex;
    logic [30:0]       m;
    logic signed [9:0] e;
    logic [5:0]        s;
    logic [65:0]       mag;
    logic [31:0]       r;
    neg = bits[31];
    ex  = bits[30:23];
    m   = {7'b0, (ex != 8'd0), bits[22:0]};
    if (is_pos) m = 31'(m * 31'd100);
    e = $signed({2'b0, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd150 + (is_pos ? 10'sd16 : 10'sd30);
    s = 6'(-e);
    r = 32'd0;
    if (ex == 8'hFF) begin
      if (bits[22:0] == 23'd0) r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (m == 31'd0) begin
      r = 32'd0;
    end else if (e >= 10'sd0) begin
      if (e > 10'sd32) r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else begin
        mag = {35'b0, m} << e[5:0];
        r = from_mag(neg, mag);
      end
    end else if (e >= -10'sd40) begin
      mag = ({35'b0, m} + (66'd1 << (s - 6'd1))) >> s;
      r = from_mag(neg, mag);
    end
    return r;
  endfunction

  // Round a sum in units of 2^-58 to Q1.30, ties away from zero.
  function automatic logic [31:0] finish_sum(input logic signed [65:0] v);
    logic        neg;
    logic [65:0] mag;
    neg = v[65];
    mag = neg ? 66'(-v) : 66'(v);
    return from_mag(neg, (mag + 66'h800_0000) >> 28);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/msp_front.sv =====
// ----------------------------------------------------------------------------
// msp_front
// Byte parser: checks the header, gathers segments and issues jobs.
// ----------------------------------------------------------------------------
module msp_front #(
  parameter int SEGMENTS     = 23,
  parameter int HEADER_BYTES = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     packet_byte,
  input  logic           end_of_packet,
  input  logic [7:0]     stale_window,
  output logic           push,
  output msp_pkg::job_t  job
);
  import msp_pkg::*;

  localparam int TOTAL = HEADER_BYTES + SEGMENTS * 32;
  localparam int PW    = $clog2(TOTAL + 1);

  logic [PW-1:0]  pos, pos_next;
  logic [PW-1:0]  off;
  logic           rejected, rejected_next;
  logic [31:0]    word_shift, word_shift_next;
  logic [31:0]    last_counter, last_counter_next;
  logic [255:0]   seg_data, seg_data_next;
  logic [31:0]    cnt;
  logic           behind;
  logic [31:0]    diff;
  status_t        reject;
  logic           seg_done;
  logic           short_pkt;

  assign off    = pos - PW'(HEADER_BYTES);
  assign cnt    = {word_shift[23:0], packet_byte};
  assign behind = $signed(cnt) < $signed(last_counter);
  assign diff   = last_counter - cnt;

  always_comb begin
    pos_next          = pos;
    rejected_next     = rejected;
    word_shift_next   = word_shift;
    last_counter_next = last_counter;
    seg_data_next     = seg_data;
    reject            = ST_OK;
    seg_done          = 1'b0;
    short_pkt         = 1'b0;
    if (accept) begin
      if (!rejected && pos < PW'(TOTAL)) begin
        if (pos < PW'(HEADER_BYTES)) begin
          if (pos < PW'(6)) begin
            if (packet_byte != MAGIC[pos[2:0]]) reject = ST_MAGIC;
          end else if (pos < PW'(10)) begin
            word_shift_next = cnt;
            if (pos == PW'(9)) begin
              if (behind && diff < {24'b0, stale_window}) reject = ST_STALE;
              else last_counter_next = cnt;
            end
          end else if (pos == PW'(11)) begin
            if (packet_byte < 8'(SEGMENTS)) reject = ST_FEW;
          end
        end else begin
          seg_data_next = {seg_data[247:0], packet_byte};
          seg_done      = (off[4:0] == 5'd31);
        end
        pos_next = pos + PW'(1);
      end
      if (reject != ST_OK) rejected_next = 1'b1;
      if (end_of_packet) begin
        short_pkt       = !rejected_next && pos_next < PW'(TOTAL);
        pos_next        = '0;
        rejected_next   = 1'b0;
        word_shift_next = '0;
      end
    end
  end

  always_comb begin
    push         = seg_done || reject != ST_OK || short_pkt;
    job.data     = seg_data_next;
    job.has_seg  = seg_done;
    job.seg_last = (off[PW-1:5] == (PW-5)'(SEGMENTS - 1));
    if (reject != ST_OK) job.status = reject;
    else if (short_pkt) job.status = ST_SHORT;
    else job.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      rejected     <= 1'b0;
      word_shift   <= '0;
      last_counter <= '0;
    end else begin
      pos          <= pos_next;
      rejected     <= rejected_next;
      word_shift   <= word_shift_next;
      last_counter <= last_counter_next;
    end
    seg_data <= seg_data_next;
  end

endmodule

// ===== sv/msp_queue.sv =====
// ----------------------------------------------------------------------------
// msp_queue
// Short job queue between the parser and the decoder.
// ----------------------------------------------------------------------------
module msp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msp_pkg::job_t  wr_job,
  input  logic           pop,
  output msp_pkg::job_t  rd_job,
  output logic           full,
  output logic           empty
);
  import msp_pkg::*;

  job_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign full   = (count == 3'd4);
  assign empty  = (count == 3'd0);
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
    if (push) mem[wp] <= wr_job;
  end

endmodule

// ===== sv/msp_back.sv =====
// ----------------------------------------------------------------------------
// msp_back
// Segment decoder: float conversion, root position, local rotation product.
// ----------------------------------------------------------------------------
module msp_back #(
  parameter int SEGMENTS = 23
) (
  input  logic           clk,
  input  logic           rst,
  input  msp_pkg::job_t  job,
  input  logic           empty,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [231:0]   m_tdata,
  output logic           m_tlast,
  output logic [2:0]     m_tuser
);
  import msp_pkg::*;

  localparam int LIMIT = (SEGMENTS < BONES) ? SEGMENTS : BONES;

  back_state_t state, state_next;

  job_t              jb;
  logic [4:0]        num;
  logic [4:0]        par;
  logic              has_parent;
  logic [2:0]        cidx;
  logic [4:0]        k;
  logic [31:0]       q [4];
  logic [31:0]       pos [3];
  logic [31:0]       offset [3];
  logic [31:0]       root_p [3];
  logic              first_packet;
  logic [127:0]      rot_mem [BONES];
  logic [BONES-1:0]  rot_valid;
  logic [127:0]      rd;
  logic              rd_valid;
  logic [31:0]       pw [4];
  logic signed [32:0] pa [4];
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [65:0] prod;
  logic              psign;
  logic [1:0]        pout;
  logic signed [65:0] acc [4];
  logic [31:0]       loc [4];
  logic [31:0]       nb;
  logic              nb_ok;
  logic [31:0]       cw;
  logic [31:0]       conv;
  logic              load;
  logic [31:0]       off_n [3];

  assign nb    = job.data[255:224];
  assign nb_ok = (nb != 32'd0) && (nb - 32'd1 < 32'(LIMIT));
  assign cw    = jb.data[(8'd255 - {CONV_WORD[cidx], 5'b0}) -: 32];
  assign conv  = to_fixed(cw ^ {CONV_NEG[cidx], 31'b0}, cidx[2]);

  // A bone not yet written reads as the identity rotation.
  always_comb begin
    pw[0] = rd_valid ? rd[127:96] : Q_ONE;
    pw[1] = rd_valid ? rd[95:64]  : 32'd0;
    pw[2] = rd_valid ? rd[63:32]  : 32'd0;
    pw[3] = rd_valid ? rd[31:0]   : 32'd0;
    pa[0] = {pw[0][31], pw[0]};
    pa[1] = -{pw[1][31], pw[1]};
    pa[2] = -{pw[2][31], pw[2]};
    pa[3] = -{pw[3][31], pw[3]};
    ma    = pa[A_SEL[k[3:0]]];
    mb    = q[B_SEL[k[3:0]]];
    for (int i = 0; i < 4; i++) loc[i] = has_parent ? finish_sum(acc[i]) : q[i];
    for (int i = 0; i < 3; i++) begin
      off_n[i] = first_packet ? sat32(-{pos[i][31], pos[i]}) : offset[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          if (job.has_seg && nb_ok) state_next = BK_CONV;
          else if (job.status != ST_OK) state_next = BK_EMIT;
        end
      end
      BK_CONV: if (cidx == 3'd6) state_next = BK_READ;
      BK_READ: state_next = has_parent ? BK_MUL : BK_FIN;
      BK_MUL:  if (k == 5'd16) state_next = BK_FIN;
      BK_FIN:  state_next = BK_EMIT;
      BK_EMIT: if (load) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && !empty;
    load = (state == BK_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      first_packet <= 1'b1;
      rot_valid    <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        offset[i] <= '0;
        root_p[i] <= '0;
      end
    end else begin
      state    <= state_next;
      m_tvalid <= load || (m_tvalid && !m_tready);
      if (state == BK_READ) begin
        rot_valid[num] <= 1'b1;
        if (num == 5'd0) begin
          first_packet <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            offset[i] <= off_n[i];
            root_p[i] <= sat32({pos[i][31], pos[i]} + {off_n[i][31], off_n[i]});
          end
        end
      end
    end

    case (state)
      BK_IDLE: begin
        jb         <= job;
        num        <= 5'(nb - 32'd1);
        par        <= PARENT[5'(nb - 32'd1)];
        has_parent <= (PARENT[5'(nb - 32'd1)] != NO_PARENT);
        cidx       <= '0;
      end
      BK_CONV: begin
        if (cidx[2]) pos[cidx[1:0]] <= conv;
        else q[cidx[1:0]] <= conv;
        cidx <= cidx + 3'd1;
      end
      BK_READ: begin
        rot_mem[num] <= {q[0], q[1], q[2], q[3]};
        rd           <= rot_mem[has_parent ? par : 5'd0];
        rd_valid     <= rot_valid[has_parent ? par : 5'd0];
        k            <= '0;
        for (int i = 0; i < 4; i++) acc[i] <= '0;
      end
      BK_MUL: begin
        if (k < 5'd16) begin
          prod  <= ma * mb;
          psign <= T_NEG[k[3:0]];
          pout  <= k[3:2];
        end
        if (k != 5'd0) begin
          acc[pout] <= psign ? acc[pout] - (prod >>> 2) : acc[pout] + (prod >>> 2);
        end
        k <= k + 5'd1;
      end
      BK_FIN: begin
        for (int i = 0; i < 4; i++) q[i] <= loc[i];
      end
      default: ;
    endcase

    if (load) begin
      m_tuser <= jb.status;
      if (jb.status != ST_OK) begin
        m_tdata <= '0;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {2'b0, (num == 5'd0), root_p[2], root_p[1], root_p[0],
                    q[3], q[2], q[1], q[0], num};
        m_tlast <= jb.seg_last;
      end
    end
  end

endmodule

// ===== sv/mocap_segment_packet_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// mocap_segment_packet_decoder_unit
// Decodes motion-capture datagrams into per-bone local rotations.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_*       in   tdata = packet_byte[7:0], tlast = end_of_packet
//  m_*       out  tdata = bone/rotation/root/is_root, tlast = last_segment,
//                 tuser = status
//  APB       in   offset 0: stale_window[7:0]
//
// One byte is taken per cycle while the job queue is not full. The sixteen
// rotation terms of each segment are formed by the single shared 33x32
// multiplier. A four-job queue separates the parser from the decoder; the
// parser stalls input only when that queue is full. Reset is synchronous.
module mocap_segment_packet_decoder_unit #(
  parameter int SEGMENTS     = 23,
  parameter int HEADER_BYTES = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // packet_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // bone_number[4:0], rot_w, rot_x, rot_y, rot_z, root_x_cm, root_y_cm,
  // root_z_cm (32 each), is_root[229], zero pad
  output logic [231:0] m_tdata,
  output logic         m_tlast,
  output logic [2:0]   m_tuser,   // status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import msp_pkg::*;

  logic [7:0] stale_window;
  logic       q_full, q_empty, q_push, q_pop;
  job_t       f_job, b_job;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {24'b0, stale_window} : 32'd0;
  assign s_tready = !q_full;

  always_ff @(posedge clk) begin
    if (rst) stale_window <= 8'd4;
    else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      stale_window <= pwdata[7:0];
    end
  end

  msp_front #(.SEGMENTS(SEGMENTS), .HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk, .rst,
    .accept(s_tvalid && s_tready),
    .packet_byte(s_tdata),
    .end_of_packet(s_tlast),
    .stale_window,
    .push(q_push),
    .job(f_job)
  );

  msp_queue u_queue (
    .clk, .rst,
    .push(q_push), .wr_job(f_job),
    .pop(q_pop), .rd_job(b_job),
    .full(q_full), .empty(q_empty)
  );

  msp_back #(.SEGMENTS(SEGMENTS)) u_back (
    .clk, .rst,
    .job(b_job), .empty(q_empty), .pop(q_pop),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

// ===== sv/msp_checker.sv =====
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [231:0] m_tdata,
  input logic         m_tlast,
  input logic [2:0]   m_tuser,
  input logic         pready
);
  import msp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // A rejection word carries nothing but its status.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0 && !m_tlast)
    else $error("status word has payload");

  a_bone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OK |-> m_tdata[4:0] < 5'd23 &&
      (m_tdata[229] == (m_tdata[4:0] == 5'd0)))
    else $error("bad bone number or root flag");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind mocap_segment_packet_decoder_unit msp_checker u_msp_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motion-capture segment decoder. Datagrams are
// streamed in one byte per word, and a behavioral decoder in the bench
// predicts every segment or status word. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import msp_pkg::*;

  localparam int SEG_COUNT    = 23;
  localparam int HDR_BYTES    = 24;
  localparam int SEG_BYTES    = 32;
  localparam int BODY_BYTES   = SEG_COUNT * SEG_BYTES;
  localparam int PKT_BYTES    = HDR_BYTES + BODY_BYTES;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 200;
  // Negative body lengths that cut the header after the counter or the count.
  localparam int TO_COUNTER   = 10 - HDR_BYTES;
  localparam int TO_SEG_COUNT = 12 - HDR_BYTES;
  localparam logic [2:0] REG_STALE_WINDOW = 3'd0;

  typedef struct {
    logic [4:0]  bone;
    logic [31:0] rot [4];
    logic [31:0] root [3];
    logic        is_root;
    logic        last;
    status_t     status;
  } seg_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [231:0] m_tdata;
  logic         m_tlast;
  logic [2:0]   m_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  mocap_segment_packet_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Decoder state mirrored in the bench.
  logic [7:0]  stale_win;
  int unsigned byte_pos;
  logic [31:0] cnt_shift;
  logic [7:0]  seg_bytes [SEG_BYTES];
  logic [31:0] last_cnt;
  logic        rejected;
  logic        first_root;
  logic [31:0] root_off [3];
  logic [31:0] root_cur [3];
  logic [31:0] raw_rot [SEG_COUNT][4];

  seg_result_t pending_segments [$];
  int          errors;
  int          cycles = 0;
  bit          tx_steady;
  bit          rx_steady;
  int          rx_hold = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_segments.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver backpressure.
  always @(negedge clk) begin
    if (rx_steady) begin
      m_tready = 1'b1;
      rx_hold  = 0;
    end else if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold  = rx_hold - 1;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold = pick_gap();
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] clamp_mag(input logic neg, input longint unsigned mag);
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return 32'(mag);
  endfunction

  // Float to Q1.30, or for positions to centimetres in Q16.16.
  function automatic logic [31:0] float_fixed(input logic [31:0] f, input logic is_pos);
    logic            neg;
    int              ex;
    int              e;
    longint unsigned m;
    neg = f[31];
    ex  = f[30:23];
    m   = f[22:0];
    if (ex == 255) begin
      if (m != 0) return 32'd0;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (ex == 0) ex = 1;
    else m = m | 64'h80_0000;
    if (is_pos) m = m * 100;
    if (m == 0) return 32'd0;
    e = ex - 150 + (is_pos ? 16 : 30);
    if (e >= 0) begin
      if (e > 32) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return clamp_mag(neg, m << e);
    end
    if (e < -40) return 32'd0;
    return clamp_mag(neg, (m + (64'd1 << (-e - 1))) >> (-e));
  endfunction

  function automatic logic [31:0] sat_sum(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Each product is floored to units of 2^-58 before the sum is rounded.
  function automatic longint prod_term(input longint a, input longint b);
    return (a * b) >>> 2;
  endfunction

  function automatic logic [31:0] round_sum(input longint s);
    logic            neg;
    longint unsigned mag;
    neg = s < 0;
    mag = neg ? -s : s;
    return clamp_mag(neg, (mag + 64'h800_0000) >> 28);
  endfunction

  function automatic logic [31:0] seg_word(input int j);
    return {seg_bytes[4*j], seg_bytes[4*j+1], seg_bytes[4*j+2], seg_bytes[4*j+3]};
  endfunction

  function automatic bit decode_segment(input int seg, output seg_result_t r);
    logic [31:0] nb;
    int          num;
    int          par;
    logic [31:0] q [4];
    logic [31:0] pos [3];
    longint      aw, ax, ay, az, bw, bx, by, bz;
    nb = seg_word(0);
    if (nb < 1 || nb > SEG_COUNT) return 0;
    num = nb - 1;
    if (num == 0) begin
      pos[0] = float_fixed(seg_word(2), 1'b1);
      pos[1] = float_fixed(seg_word(1), 1'b1);
      pos[2] = float_fixed(seg_word(3), 1'b1);
      if (first_root) begin
        for (int i = 0; i < 3; i++) root_off[i] = sat_sum(-longint'(signed'(pos[i])));
        first_root = 1'b0;
      end
      for (int i = 0; i < 3; i++)
        root_cur[i] = sat_sum(longint'(signed'(pos[i])) + longint'(signed'(root_off[i])));
    end
    q[0] = float_fixed(seg_word(4), 1'b0);
    q[1] = float_fixed(seg_word(6) ^ 32'h8000_0000, 1'b0);
    q[2] = float_fixed(seg_word(5) ^ 32'h8000_0000, 1'b0);
    q[3] = float_fixed(seg_word(7) ^ 32'h8000_0000, 1'b0);
    if (PARENT[num] == NO_PARENT) begin
      r.rot = q;
    end else begin
      par = PARENT[num];
      aw = signed'(raw_rot[par][0]);
      ax = -longint'(signed'(raw_rot[par][1]));
      ay = -longint'(signed'(raw_rot[par][2]));
      az = -longint'(signed'(raw_rot[par][3]));
      bw = signed'(q[0]);
      bx = signed'(q[1]);
      by = signed'(q[2]);
      bz = signed'(q[3]);
      r.rot[0] = round_sum(prod_term(aw, bw) - prod_term(ax, bx) - prod_term(ay, by)
                           - prod_term(az, bz));
      r.rot[1] = round_sum(prod_term(aw, bx) + prod_term(ax, bw) + prod_term(ay, bz)
                           - prod_term(az, by));
      r.rot[2] = round_sum(prod_term(aw, by) - prod_term(ax, bz) + prod_term(ay, bw)
                           + prod_term(az, bx));
      r.rot[3] = round_sum(prod_term(aw, bz) + prod_term(ax, by) - prod_term(ay, bx)
                           + prod_term(az, bw));
    end
    raw_rot[num] = q;
    r.bone    = 5'(num);
    r.root    = root_cur;
    r.is_root = (num == 0);
    r.last    = (seg == SEG_COUNT - 1);
    r.status  = ST_OK;
    return 1;
  endfunction

  function automatic seg_result_t status_word(input status_t st);
    seg_result_t r;
    r.bone    = '0;
    r.rot     = '{default: '0};
    r.root    = '{default: '0};
    r.is_root = 1'b0;
    r.last    = 1'b0;
    r.status  = st;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eop);
    seg_result_t r;
    bit          have;
    status_t     rej;
    int          off;
    have = 0;
    rej  = ST_OK;
    if (!rejected && byte_pos < PKT_BYTES) begin
      if (byte_pos < 6) begin
        if (b != MAGIC[byte_pos]) rej = ST_MAGIC;
      end else if (byte_pos < 10) begin
        cnt_shift = {cnt_shift[23:0], b};
        if (byte_pos == 9) begin
          if (signed'(cnt_shift) < signed'(last_cnt) && (last_cnt - cnt_shift) < stale_win)
            rej = ST_STALE;
          else last_cnt = cnt_shift;
        end
      end else if (byte_pos == 11) begin
        if (b < SEG_COUNT) rej = ST_FEW;
      end else if (byte_pos >= HDR_BYTES) begin
        off = byte_pos - HDR_BYTES;
        seg_bytes[off % SEG_BYTES] = b;
        if (off % SEG_BYTES == SEG_BYTES - 1) have = decode_segment(off / SEG_BYTES, r);
      end
      byte_pos++;
    end
    if (rej != ST_OK) begin
      rejected = 1'b1;
      r = status_word(rej);
      have = 1;
    end
    if (eop) begin
      // A short datagram reports itself even over a segment of the same word.
      if (!rejected && byte_pos < PKT_BYTES) begin
        r = status_word(ST_SHORT);
        have = 1;
      end
      byte_pos  = 0;
      rejected  = 1'b0;
      cnt_shift = '0;
    end
    if (have) pending_segments.push_back(r);
  endtask

  // ---------------------------------------------------------------- checker
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    seg_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected word, actual tdata %h tuser %0d", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        w = pending_segments.pop_front();
        check_field("bone_number", 32'(w.bone), 32'(m_tdata[4:0]));
        check_field("rot_w", w.rot[0], m_tdata[36:5]);
        check_field("rot_x", w.rot[1], m_tdata[68:37]);
        check_field("rot_y", w.rot[2], m_tdata[100:69]);
        check_field("rot_z", w.rot[3], m_tdata[132:101]);
        check_field("root_x_cm", w.root[0], m_tdata[164:133]);
        check_field("root_y_cm", w.root[1], m_tdata[196:165]);
        check_field("root_z_cm", w.root[2], m_tdata[228:197]);
        check_field("is_root", 32'(w.is_root), 32'(m_tdata[229]));
        check_field("last_segment", 32'(w.last), 32'(m_tlast));
        check_field("status", 32'(w.status), 32'(m_tuser));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = (tx_steady || $urandom_range(0, 4) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eop;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b, eop);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_bytes(input logic [7:0] pkt [$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic settle();
    while (pending_segments.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (pready && addr == REG_STALE_WINDOW) stale_win = data[7:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [31:0] rand_float(input bit is_pos);
    logic sgn;
    sgn = $urandom_range(0, 1);
    case ($urandom_range(0, 15))
      0: return {sgn, 31'd0};
      1: return {sgn, 8'hFF, 23'd0};
      2: return {sgn, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return {sgn, 8'h00, 23'($urandom)};
      4: return {sgn, 8'($urandom_range(128, 254)), 23'($urandom)};
      5: return $urandom;
      6: return {sgn, 8'($urandom_range(1, 100)), 23'($urandom)};
      default: begin
        if (is_pos) return {sgn, 8'($urandom_range(112, 134)), 23'($urandom)};
        return {sgn, 8'($urandom_range(118, 127)), 23'($urandom)};
      end
    endcase
  endfunction

  function automatic logic [31:0] next_counter();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return last_cnt + $urandom_range(1, 300);
  endfunction

  // Full header, then body_len body bytes; the last byte carries end of packet.
  // A negative body_len cuts the header short by that many bytes.
  task automatic send_packet(input logic [31:0] cnt, input logic [7:0] nseg,
                             input int body_len, input int bad_bone_pct, input bit shuffled);
    logic [7:0]  pkt [$];
    logic [31:0] w;
    int          s;
    for (int i = 0; i < 6; i++) pkt.push_back(MAGIC[i]);
    for (int i = 3; i >= 0; i--) pkt.push_back(cnt[8*i +: 8]);
    pkt.push_back(8'($urandom));
    pkt.push_back(nseg);
    for (int i = 0; i < 12; i++) pkt.push_back(8'($urandom));
    s = 0;
    while (pkt.size() < HDR_BYTES + body_len) begin
      for (int j = 0; j < 8; j++) begin
        if (j == 0) begin
          w = shuffled ? $urandom_range(1, SEG_COUNT) : (s % SEG_COUNT) + 1;
          if ($urandom_range(0, 99) < bad_bone_pct)
            case ($urandom_range(0, 3))
              0: w = 0;
              1: w = SEG_COUNT + 1;
              2: w = 32'hFFFF_FFFF;
              default: w = $urandom;
            endcase
        end else begin
          w = rand_float(j < 4);
        end
        for (int i = 3; i >= 0; i--) pkt.push_back(w[8*i +: 8]);
      end
      s++;
    end
    while (pkt.size() > HDR_BYTES + body_len) void'(pkt.pop_back());
    send_bytes(pkt);
  endtask

  // Correct magic up to bad_at, then a wrong byte and some trailing noise.
  task automatic send_bad_magic(input int bad_at, input int tail);
    logic [7:0] pkt [$];
    logic [7:0] b;
    for (int i = 0; i < bad_at; i++) pkt.push_back(MAGIC[i]);
    b = $urandom;
    while (b == MAGIC[bad_at]) b = $urandom;
    pkt.push_back(b);
    for (int i = 0; i < tail; i++) pkt.push_back(8'($urandom));
    send_bytes(pkt);
  endtask

  task automatic test_header_checks();
    logic [7:0] pkt [$];
    apb_write(REG_STALE_WINDOW, 32'd4);
    for (int k = 0; k < 6; k++) send_bad_magic(k, 1);
    // End of packet on the very first byte, then inside the counter.
    pkt = '{MAGIC[0]};
    send_bytes(pkt);
    pkt = '{MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3], MAGIC[4], MAGIC[5], 8'h00, 8'h00};
    send_bytes(pkt);
    // Counter just behind the last one, then a too small and an ample segment count.
    send_packet(32'hFFFF_FFFF, 8'd23, TO_COUNTER, 0, 0);
    send_packet(32'd5, 8'd22, TO_SEG_COUNT, 0, 0);
    send_packet(32'd6, 8'd255, TO_SEG_COUNT, 0, 0);
    settle();
  endtask

  task automatic test_full_packets(input int n);
    for (int i = 0; i < n; i++) send_packet(next_counter(), 8'($urandom_range(23, 255)),
                                            BODY_BYTES, 0, 0);
    settle();
  endtask

  task automatic test_segment_edges();
    // End of packet mid segment, then on the last byte of an inner segment.
    send_packet(next_counter(), 8'd23, 2 * SEG_BYTES + 13, 30, 1);
    send_packet(next_counter(), 8'd23, 2 * SEG_BYTES, 0, 0);
    settle();
  endtask

  task automatic test_stale_window(input logic [7:0] win);
    logic [31:0] base;
    apb_write(REG_STALE_WINDOW, {24'd0, win});
    base = last_cnt;
    send_packet(base - 1, 8'd23, TO_COUNTER, 0, 0);
    send_packet(base - win + 1, 8'd23, TO_COUNTER, 0, 0);
    send_packet(last_cnt - win, 8'd23, TO_COUNTER, 0, 0);
    send_packet(last_cnt - win - 1, 8'd23, TO_COUNTER, 0, 0);
    send_packet(last_cnt, 8'd23, TO_COUNTER, 0, 0);
    send_packet(last_cnt ^ 32'h8000_0000, 8'd23, TO_COUNTER, 0, 0);
    send_packet(last_cnt + 1, 8'd23, TO_COUNTER, 0, 0);
    settle();
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: send_packet(next_counter(), 8'd23, $urandom_range(0, SEG_BYTES + 8), 10, 1);
        1: send_bad_magic($urandom_range(0, 5), $urandom_range(0, 6));
        2: send_packet(last_cnt - $urandom_range(0, 8), 8'd23, TO_COUNTER, 0, 0);
        3: send_packet(next_counter(), 8'($urandom_range(0, 22)), TO_SEG_COUNT, 0, 0);
        default: send_packet(next_counter(), 8'($urandom_range(23, 255)), SEG_BYTES + 8, 5,
                             $urandom_range(0, 1));
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
    end
    tx_steady = 0;
    rx_steady = 0;
    settle();
  endtask

  task automatic test_drained_packets();
    tx_steady = 1;
    rx_steady = 1;
    for (int i = 0; i < 2; i++) begin
      send_packet(next_counter(), 8'd23, SEG_BYTES, 0, 0);
      while (pending_segments.size() != 0) @(negedge clk);
    end
    tx_steady = 0;
    rx_steady = 0;
    settle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    tx_steady = 0;
    rx_steady = 0;
    stale_win = 8'd4;
    byte_pos = 0;
    cnt_shift = '0;
    last_cnt = '0;
    rejected = 1'b0;
    first_root = 1'b1;
    root_off = '{default: '0};
    root_cur = '{default: '0};
    foreach (seg_bytes[i]) seg_bytes[i] = '0;
    for (int i = 0; i < SEG_COUNT; i++) raw_rot[i] = '{Q_ONE, 32'd0, 32'd0, 32'd0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_header_checks();
    test_full_packets(1);
    test_segment_edges();
    test_stale_window(8'd0);
    test_stale_window(8'd255);
    test_drained_packets();
    apb_write(REG_STALE_WINDOW, 32'd4);
    test_random_traffic(3);

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
sv/msp_pkg.sv
sv/msp_front.sv
sv/msp_queue.sv
sv/msp_back.sv
sv/mocap_segment_packet_decoder_unit.sv
sv/msp_checker.sv
bench/tb_top.sv
